@@ rtl/stbs_pkg.sv @@
// Package with the item types and shared constants of the sorted table bound search.
`default_nettype none

package stbs_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned ModeW  = 2;
  localparam int unsigned IndexW = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = IndexW + 1;

  // Item mode codes. The fourth code is unused and the item is dropped.
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd0;
  localparam logic [ModeW-1:0] MODE_LOWER = 2'd1;
  localparam logic [ModeW-1:0] MODE_UPPER = 2'd2;

  // One input item.
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic [IndexW-1:0]        entry_index;
    logic signed [ValueW-1:0] entry_value;
    logic [IndexW-1:0]        range_low;
    logic [IndexW-1:0]        range_high;
    logic signed [ValueW-1:0] search_key;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [PosW-1:0] position;
    logic            none_found;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/sorted_table_bound_search_top.sv @@
// Top level of the sorted table bound search: table, search sequencer and result register.
`default_nettype none

// Channel  Direction  Payload               Handshake
// in       input      stbs_pkg::in_item_t   in_valid_i / in_stall_o
// out      output     stbs_pkg::out_item_t  out_valid_o / out_stall_i
//
// A write item produces no result; an item with the unused mode is dropped.
// A query starts from idle, probes the table at one probe per cycle (up to nine probes for a
// 256-entry range) and then moves its result into the output register; the single table
// read port sets this rate, since each probe depends on the previous compare.
// Reset clears the control state only; table entries hold nothing until written.
// A stalled result holds the sequencer in its done state, and new items are stalled then.

module sorted_table_bound_search_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire stbs_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output stbs_pkg::out_item_t      out_data_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                               wr_en;
  logic [AddrW-1:0]                   wr_addr;
  logic signed [stbs_pkg::ValueW-1:0] wr_data;
  logic                               rd_en;
  logic [AddrW-1:0]                   rd_addr;
  logic signed [stbs_pkg::ValueW-1:0] rd_data;
  logic                               res_valid;
  logic                               res_take;
  stbs_pkg::out_item_t                res;
  logic                               out_valid_q, out_valid_d;
  stbs_pkg::out_item_t                out_q;

  stbs_table #(
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stbs_search #(
    .TableDepth(TABLE_DEPTH)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // The output register takes a result when empty or when its transfer completes.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/stbs_table.sv @@
// Value table: synchronous memory with one write port and one registered read port.
`default_nettype none

module stbs_table #(
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               wr_en_i,
  input  wire logic [AddrW-1:0]                   wr_addr_i,
  input  wire logic signed [stbs_pkg::ValueW-1:0] wr_data_i,
  input  wire logic                               rd_en_i,
  input  wire logic [AddrW-1:0]                   rd_addr_i,
  output logic signed [stbs_pkg::ValueW-1:0]      rd_data_o
);

  logic signed [stbs_pkg::ValueW-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/stbs_search.sv @@
// Search sequencer: takes items, writes the table and runs the halving search on it.
`default_nettype none

module stbs_search #(
  parameter int unsigned TableDepth = 256,
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Item side.
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire stbs_pkg::in_item_t                 in_data_i,
  // Table ports.
  output logic                                    wr_en_o,
  output logic [AddrW-1:0]                        wr_addr_o,
  output logic signed [stbs_pkg::ValueW-1:0]      wr_data_o,
  output logic                                    rd_en_o,
  output logic [AddrW-1:0]                        rd_addr_o,
  input  wire logic signed [stbs_pkg::ValueW-1:0] rd_data_i,
  // Result side.
  output logic                                    res_valid_o,
  output stbs_pkg::out_item_t                     res_o,
  input  wire logic                               res_take_i
);

  localparam int unsigned PosW = stbs_pkg::PosW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

  // Probe point of a nonempty range [lo, hi1 - 1], rounded down.
  function automatic logic [PosW-1:0] mid_of(logic [PosW-1:0] lo, logic [PosW-1:0] hi1);
    logic [PosW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi1} - {{PosW{1'b0}}, 1'b1};
    return sum[PosW:1];
  endfunction

  // An index past the end of the table is never stored and reads as zero.
  function automatic logic in_table(logic [PosW-1:0] idx);
    return 32'(idx) < 32'(TableDepth);
  endfunction

  state_e                             state_q, state_d;
  logic [PosW-1:0]                    lo_q, lo_d;
  logic [PosW-1:0]                    hi1_q, hi1_d;
  logic [PosW-1:0]                    mid_q, mid_d;
  logic [PosW-1:0]                    pos_q, pos_d;
  logic [PosW-1:0]                    rh1_q, rh1_d;
  logic                               found_q, found_d;
  logic                               upper_q, upper_d;
  logic                               oor_q, oor_d;
  logic signed [stbs_pkg::ValueW-1:0] key_q, key_d;

  logic                               accept;
  logic                               is_query;
  logic [PosW-1:0]                    q_lo;
  logic [PosW-1:0]                    q_hi1;
  logic signed [stbs_pkg::ValueW-1:0] probe_val;
  logic                               hit;
  logic [PosW-1:0]                    step_lo;
  logic [PosW-1:0]                    step_hi1;
  logic [PosW-1:0]                    next_mid;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign is_query   = (in_data_i.mode == stbs_pkg::MODE_LOWER) ||
                      (in_data_i.mode == stbs_pkg::MODE_UPPER);

  // Table writes happen only from idle, so a later probe always sees them.
  assign wr_en_o   = accept && (in_data_i.mode == stbs_pkg::MODE_WRITE) &&
                     in_table({1'b0, in_data_i.entry_index});
  assign wr_addr_o = AddrW'(in_data_i.entry_index);
  assign wr_data_o = in_data_i.entry_value;

  // Query bounds, with the upper bound kept as one past the last index.
  assign q_lo  = {1'b0, in_data_i.range_low};
  assign q_hi1 = {1'b0, in_data_i.range_high} + {{(PosW-1){1'b0}}, 1'b1};

  // Compare the probed entry and narrow the range.
  assign probe_val = oor_q ? '0 : rd_data_i;
  assign hit       = upper_q ? (probe_val > key_q) : (probe_val >= key_q);
  assign step_lo   = hit ? lo_q : (mid_q + {{(PosW-1){1'b0}}, 1'b1});
  assign step_hi1  = hit ? mid_q : hi1_q;
  assign next_mid  = mid_of(step_lo, step_hi1);

  // Next state and read issue.
  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi1_d     = hi1_q;
    mid_d     = mid_q;
    pos_d     = pos_q;
    rh1_d     = rh1_q;
    found_d   = found_q;
    upper_d   = upper_q;
    oor_d     = oor_q;
    key_d     = key_q;
    rd_en_o   = 1'b0;
    rd_addr_o = AddrW'(mid_q);
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_query) begin
          lo_d    = q_lo;
          hi1_d   = q_hi1;
          rh1_d   = q_hi1;
          pos_d   = q_hi1;
          found_d = 1'b0;
          upper_d = (in_data_i.mode == stbs_pkg::MODE_UPPER);
          key_d   = in_data_i.search_key;
          if (q_lo < q_hi1) begin
            mid_d     = mid_of(q_lo, q_hi1);
            oor_d     = !in_table(mid_d);
            rd_en_o   = 1'b1;
            rd_addr_o = AddrW'(mid_d);
            state_d   = S_SEARCH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        lo_d  = step_lo;
        hi1_d = step_hi1;
        if (hit) begin
          pos_d   = mid_q;
          found_d = 1'b1;
        end
        if (step_lo < step_hi1) begin
          mid_d     = next_mid;
          oor_d     = !in_table(next_mid);
          rd_en_o   = 1'b1;
          rd_addr_o = AddrW'(next_mid);
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and search registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lo_q    <= '0;
      hi1_q   <= '0;
      mid_q   <= '0;
      pos_q   <= '0;
      rh1_q   <= '0;
      found_q <= 1'b0;
      upper_q <= 1'b0;
      oor_q   <= 1'b0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi1_q   <= hi1_d;
      mid_q   <= mid_d;
      pos_q   <= pos_d;
      rh1_q   <= rh1_d;
      found_q <= found_d;
      upper_q <= upper_d;
      oor_q   <= oor_d;
      key_q   <= key_d;
    end
  end

  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.position   = pos_q;
  assign res_o.none_found = !found_q;

  // The live range is never empty while a probe is outstanding.
  a_range_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (lo_q < hi1_q))
    else $error("search running on an empty range");

  // The outstanding probe lies inside the live range.
  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> ((mid_q >= lo_q) && (mid_q < hi1_q)))
    else $error("probe index outside the live range");

  // A result never points past one beyond the range end.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.position <= rh1_q))
    else $error("result position beyond range end plus one");

  // A miss reports exactly one past the range end.
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.none_found) |-> (res_o.position == rh1_q))
    else $error("miss does not report range end plus one");

endmodule

`default_nettype wire

@@ tb/sv/bound_search_checker.sv @@
`timescale 1ns / 1ps
// Checker that mirrors the search table, predicts each query result and compares it.
module bound_search_checker
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  // Shadow copy of the table, updated by every accepted write transfer.
  logic signed [ValueW-1:0] shadow_table [TABLE_DEPTH];
  // Results predicted for accepted queries, oldest first.
  out_item_t                expected_results [$];
  out_item_t                oldest_result;
  int                       fail_count    = 0;
  int                       pending_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  // Halving search over the shadow table for one query.
  function automatic out_item_t bound_search(input in_item_t query);
    out_item_t                answer;
    int                       lo;
    int                       hi;
    int                       mid;
    logic signed [ValueW-1:0] probe;
    logic                     hit;
    lo                = int'(query.range_low);
    hi                = int'(query.range_high);
    answer.position   = PosW'(hi + 1);
    answer.none_found = 1'b1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      // Probes beyond a shallow table read as zero.
      probe = (mid < int'(TABLE_DEPTH)) ? shadow_table[mid] : '0;
      if (query.mode == MODE_LOWER) begin
        hit = ($signed(probe) >= $signed(query.search_key));
      end else begin
        hit = ($signed(probe) > $signed(query.search_key));
      end
      if (hit) begin
        answer.position   = PosW'(mid);
        answer.none_found = 1'b0;
        hi                = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return answer;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Results are checked before the input transfer of the same edge is predicted,
  // since a result leaving now always belongs to an older query.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      pending_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, position", int'(out_data_i.position), -1);
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data_i.position !== oldest_result.position) begin
            report_mismatch("position", int'(out_data_i.position),
                            int'(oldest_result.position));
          end
          if (out_data_i.none_found !== oldest_result.none_found) begin
            report_mismatch("none_found", int'(out_data_i.none_found),
                            int'(oldest_result.none_found));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.mode)
          MODE_WRITE: begin
            if (int'(in_data_i.entry_index) < int'(TABLE_DEPTH)) begin
              shadow_table[in_data_i.entry_index] = in_data_i.entry_value;
            end
          end
          MODE_LOWER, MODE_UPPER: begin
            expected_results.push_back(bound_search(in_data_i));
          end
          default: begin
            // The unused mode is dropped by the block.
          end
        endcase
      end
      pending_count = expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_sorted_table_bound_search_top.sv @@
`timescale 1ns / 1ps
// Testbench top: drives table writes and bound queries into the search block and gives the verdict.
module tb_sorted_table_bound_search_top;
  import stbs_pkg::*;

  localparam int unsigned               RandomItems    = 1750;
  localparam int unsigned               QuietItems     = 150;
  localparam int unsigned               HoldAfterItems = 600;
  localparam int unsigned               LongHold       = 300;
  localparam int unsigned               DrainCycles    = 24;
  localparam int unsigned               CycleLimit     = 400000;
  localparam logic [ModeW-1:0]          ModeUnused     = 2'd3;
  localparam logic signed [ValueW-1:0]  MinValue       = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0]  MaxValue       = 32'sh7fff_ffff;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int items_sent   = 0;
  int random_count = 0;
  int cycle_count  = 0;
  bit quiet_tail   = 1'b0;
  int region_lo;
  int region_hi;

  // Values written so far, used only to pick keys close to table contents.
  logic signed [ValueW-1:0] written_values [256];

  sorted_table_bound_search_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  bound_search_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > int'(CycleLimit)) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off, and none in the quiet tail.
  initial begin
    int burst_left;
    int hold_left;
    bit hold_done;
    burst_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= int'(HoldAfterItems)) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one item, after an optional idle burst, and waits for its transfer.
  task automatic push_item(input in_item_t item);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Table write; the query fields carry random filler.
  task automatic send_write(input int index, input logic signed [ValueW-1:0] value);
    in_item_t item;
    item.mode        = MODE_WRITE;
    item.entry_index = IndexW'(index);
    item.entry_value = value;
    item.range_low   = IndexW'($urandom);
    item.range_high  = IndexW'($urandom);
    item.search_key  = $urandom;
    written_values[index] = value;
    push_item(item);
  endtask

  // Bound query; the write fields carry random filler.
  task automatic send_query(input logic [ModeW-1:0] mode, input int lo, input int hi,
                            input logic signed [ValueW-1:0] key);
    in_item_t item;
    item.mode        = mode;
    item.entry_index = IndexW'($urandom);
    item.entry_value = $urandom;
    item.range_low   = IndexW'(lo);
    item.range_high  = IndexW'(hi);
    item.search_key  = key;
    push_item(item);
  endtask

  // Counts a random item and switches off idling for the last stretch.
  task automatic count_random_item();
    random_count++;
    if (random_count >= int'(RandomItems - QuietItems)) begin
      quiet_tail = 1'b1;
    end
  endtask

  // Fills a region with ascending values (duplicates allowed) or with scrambled ones.
  task automatic fill_region(input int lo, input int hi, input bit ascending);
    longint level;
    longint step_max;
    case ($urandom_range(0, 3))
      0:       step_max = 2;
      1:       step_max = 1000;
      2:       step_max = 64'd1 << 20;
      default: step_max = 64'd1 << 25;
    endcase
    level = ($urandom_range(0, 2) == 0) ? longint'(MinValue) : longint'($signed($urandom));
    for (int i = lo; i <= hi; i++) begin
      if (level > longint'(MaxValue)) begin
        level = longint'(MaxValue);
      end
      if (ascending) begin
        send_write(i, ValueW'(level));
      end else begin
        send_write(i, $urandom);
      end
      count_random_item();
      level += longint'($urandom_range(0, int'(step_max)));
    end
  endtask

  // One random query or noise item inside a phase.
  task automatic random_query();
    int                       pick;
    int                       lo;
    int                       hi;
    int                       idx;
    int                       delta;
    logic [ModeW-1:0]         mode;
    logic signed [ValueW-1:0] key;
    in_item_t                 noise;
    pick = $urandom_range(0, 99);
    mode = ($urandom_range(0, 1) == 0) ? MODE_LOWER : MODE_UPPER;
    if (pick < 4) begin
      // Unused mode: random content, ignored by the block and not counted.
      noise      = in_item_t'({$urandom, $urandom, $urandom});
      noise.mode = ModeUnused;
      push_item(noise);
    end else if (pick < 10) begin
      // Stray write that may break the ordering of the table.
      send_write($urandom_range(0, 255), $urandom);
      count_random_item();
    end else if (pick < 15) begin
      // Empty range: nothing is probed.
      lo = $urandom_range(1, 255);
      hi = $urandom_range(0, lo - 1);
      send_query(mode, lo, hi, $urandom);
      count_random_item();
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          lo = 0;
          hi = 255;
        end
        1: begin
          lo = $urandom_range(region_lo, region_hi);
          hi = $urandom_range(lo, region_hi);
        end
        default: begin
          lo = $urandom_range(0, 255);
          hi = $urandom_range(lo, 255);
        end
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // Keys next to a stored value hit the equal and off-by-one cases.
        idx   = $urandom_range(0, 255);
        delta = $urandom_range(0, 2);
        key   = written_values[idx] + ValueW'(delta) - ValueW'(1);
      end else if (pick < 8) begin
        key = $urandom;
      end else if (pick == 8) begin
        key = MinValue;
      end else begin
        key = MaxValue;
      end
      send_query(mode, lo, hi, key);
      count_random_item();
    end
  endtask

  // Stimulus: reset, directed cases, random phases, drain and verdict.
  initial begin
    int queries;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: extreme values and indexes, both modes, hits and misses.
    send_write(0, MinValue);
    send_write(1, -32'sd5);
    send_write(2, 32'sd7);
    send_write(3, MaxValue);
    send_write(254, 32'sd0);
    send_write(255, MaxValue);
    send_query(MODE_LOWER, 0, 3, MinValue);
    send_query(MODE_UPPER, 0, 3, MinValue);
    send_query(MODE_LOWER, 0, 3, 32'sd7);
    send_query(MODE_UPPER, 0, 3, 32'sd7);
    // Nothing above the largest value: the answer is one past the range.
    send_query(MODE_UPPER, 0, 3, MaxValue);
    send_query(MODE_LOWER, 254, 255, MaxValue);
    send_query(MODE_UPPER, 255, 255, MaxValue);
    send_query(MODE_LOWER, 255, 255, MinValue);
    send_query(MODE_LOWER, 0, 0, -32'sd5);
    send_query(MODE_UPPER, 1, 1, -32'sd5);
    // Empty ranges probe nothing.
    send_query(MODE_LOWER, 3, 0, 32'sd0);
    send_query(MODE_UPPER, 255, 254, MinValue);
    // Unused mode with every bit set is dropped.
    push_item('1);
    // An unsorted stretch still follows the probe order.
    send_write(4, 32'sd100);
    send_write(5, -32'sd100);
    send_write(6, 32'sd50);
    send_query(MODE_LOWER, 4, 6, 32'sd60);
    send_query(MODE_UPPER, 4, 6, -32'sd200);

    // Random phases: the first fills the whole table, later ones refill a region.
    region_lo = 0;
    region_hi = 255;
    fill_region(0, 255, 1'b1);
    while (random_count < int'(RandomItems)) begin
      queries = $urandom_range(120, 220);
      for (int q = 0; q < queries && random_count < int'(RandomItems); q++) begin
        random_query();
      end
      if (random_count < int'(RandomItems)) begin
        if ($urandom_range(0, 3) == 0) begin
          region_lo = 0;
          region_hi = 255;
        end else begin
          region_lo = $urandom_range(0, 255);
          region_hi = region_lo + $urandom_range(0, 63);
          if (region_hi > 255) begin
            region_hi = 255;
          end
        end
        fill_region(region_lo, region_hi, $urandom_range(0, 5) != 0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
